/* sv/sfd_pkg.sv */
// Shared types, codes and helper functions for the frame deframer with CRC-32.
`timescale 1ns / 1ps

package sfd_pkg;

  // Default frame length cap; the top level takes this as its parameter default.
  localparam int MAX_FRAME_BYTES_DEF = 142;
  // Shortest complete frame: sync, marker, four CRC bytes, count byte.
  localparam logic [7:0] MIN_FRAME_BYTES = 8'd7;

  // Frame phase positions held in frame_count.
  localparam logic [7:0] FC_IDLE   = 8'd0;
  localparam logic [7:0] FC_MARK   = 8'd1;
  localparam logic [7:0] FC_COUNT  = 8'd6;

  localparam logic [7:0] SYNC_BYTE   = 8'h92;
  localparam logic [7:0] MARK_BYTE   = 8'hCE;
  localparam logic [3:0] COUNT_NIB   = 4'h9;   // count byte is 0x90 + n
  localparam logic [7:0] TYPE_FALSE  = 8'hC2;
  localparam logic [7:0] TYPE_TRUE   = 8'hC3;
  localparam logic [7:0] TYPE_FLOAT  = 8'hCA;
  localparam logic [7:0] TYPE_DOUBLE = 8'hCB;
  localparam logic [7:0] TYPE_U8     = 8'hCC;
  localparam logic [7:0] TYPE_U64    = 8'hCF;
  localparam logic [7:0] TYPE_S8     = 8'hD0;
  localparam logic [7:0] TYPE_S64    = 8'hD3;
  localparam logic [7:0] STR_FIRST   = 8'hA0;
  localparam logic [7:0] STR_LAST    = 8'hAF;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [3:0] KIND_BOOL      = 4'd0;
  localparam logic [3:0] KIND_UINT_BASE = 4'd1;
  localparam logic [3:0] KIND_SINT_BASE = 4'd5;
  localparam logic [3:0] KIND_FLOAT     = 4'd9;
  localparam logic [3:0] KIND_DOUBLE    = 4'd10;
  localparam logic [3:0] KIND_STRING    = 4'd11;

  localparam logic [3:0] LEN_FLOAT  = 4'd4;
  localparam logic [3:0] LEN_DOUBLE = 4'd8;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_OK      = 2'd1,
    ST_CRC_BAD = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_COUNT  = 2'd1,
    ROLE_TYPE   = 2'd2,
    ROLE_DATA   = 2'd3
  } role_t;

  typedef struct packed {
    logic [7:0]  frame_count;
    logic [31:0] crc_expected;
    logic [31:0] crc_running;
    logic [3:0]  objects_left;
    logic [3:0]  payload_left;
    logic [3:0]  current_index;
    logic [3:0]  current_kind;
    logic [63:0] value_shift;
  } state_t;

  typedef struct packed {
    status_t     status;
    role_t       role;
    logic [3:0]  index;
    logic [3:0]  kind;
    logic        obj_end;
    logic [63:0] value;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] kind;
    logic [3:0] len;
  } type_dec_t;

  // One byte of reflected CRC-32 on a finalized (inverted) value.
  function automatic logic [31:0] crc_byte(input logic [31:0] fin, input logic [7:0] b);
    logic [31:0] c;
    c = ~fin ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  function automatic type_dec_t decode_type(input logic [7:0] b);
    type_dec_t d;
    d = '0;
    priority if (b == TYPE_FALSE || b == TYPE_TRUE) begin
      d.ok   = 1'b1;
      d.kind = KIND_BOOL;
    end else if (b >= TYPE_U8 && b <= TYPE_U64) begin
      d.ok   = 1'b1;
      d.kind = KIND_UINT_BASE + {2'b00, b[1:0]};
      d.len  = 4'd1 << b[1:0];
    end else if (b >= TYPE_S8 && b <= TYPE_S64) begin
      d.ok   = 1'b1;
      d.kind = KIND_SINT_BASE + {2'b00, b[1:0]};
      d.len  = 4'd1 << b[1:0];
    end else if (b == TYPE_FLOAT) begin
      d.ok   = 1'b1;
      d.kind = KIND_FLOAT;
      d.len  = LEN_FLOAT;
    end else if (b == TYPE_DOUBLE) begin
      d.ok   = 1'b1;
      d.kind = KIND_DOUBLE;
      d.len  = LEN_DOUBLE;
    end else if (b >= STR_FIRST && b <= STR_LAST) begin
      d.ok   = 1'b1;
      d.kind = KIND_STRING;
      d.len  = b[3:0];
    end else begin
      d.ok   = 1'b0;
    end
    return d;
  endfunction

endpackage

/* sv/stream_frame_deframer_crc.sv */
// Top level: byte-stream frame deframer with running CRC-32 and per-byte tags.
`timescale 1ns / 1ps
// Path: a byte taken into the input register is parsed and its tag written to the output register
// when the output stage can take it. One byte per cycle unless out_stall holds the output; the parse
//   step, CRC byte update and type decode all sit between the input register and the output register.
// Reset (rst_n, synchronous, active low): both stages empty, parser back to idle with
//   zeroed counters and CRC; payload registers are not cleared.

module stream_frame_deframer_crc #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [1:0]  out_byte_role,
  output logic [3:0]  out_object_index,
  output logic [3:0]  out_object_kind,
  output logic        out_object_end,
  output logic [63:0] out_object_value
);

  // Input stage: one byte waiting to be parsed.
  logic             in_vld_r;
  logic [7:0]       in_byte_r;

  // Output stage: tag of the last parsed byte, waiting for the consumer.
  logic             out_vld_r;
  sfd_pkg::result_t res_r;
  sfd_pkg::result_t res_nxt;

  // Parser state lives here; it advances only when a byte moves to the output stage.
  sfd_pkg::state_t  state_r;
  sfd_pkg::state_t  state_nxt;

  logic             adv;

  // A byte moves forward when the output stage is empty or is being drained this cycle.
  // The input register can take one new byte while the previous tag is still waiting;
  // once that byte cannot move forward, in_stall holds off the next one.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  sfd_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parse (
    .state_cur (state_r),
    .data_byte (in_byte_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
      state_r   <= state_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_frame_status = res_r.status;
  assign out_byte_role    = res_r.role;
  assign out_object_index = res_r.index;
  assign out_object_kind  = res_r.kind;
  assign out_object_end   = res_r.obj_end;
  assign out_object_value = res_r.value;

`ifndef SYNTHESIS
  // A rejected byte carries no tag content.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status == sfd_pkg::ST_REJECT) |->
      (out_byte_role == sfd_pkg::ROLE_HEADER && out_object_index == '0 &&
       out_object_kind == '0 && !out_object_end && out_object_value == '0))
    else $error("rejected byte has nonzero tag");

  // Object end only on type or data bytes.
  a_end_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_object_end) |->
      (out_byte_role == sfd_pkg::ROLE_TYPE || out_byte_role == sfd_pkg::ROLE_DATA))
    else $error("object end on header or count byte");

  // Frame length never passes the cap.
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.frame_count <= 8'(MAX_FRAME_BYTES))
    else $error("frame count above cap");

  // A bool never has payload bytes outstanding.
  a_bool_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.payload_left != '0) |-> (state_r.current_kind != sfd_pkg::KIND_BOOL))
    else $error("payload pending on bool object");

  // A good CRC closes the frame: parser returns to idle.
  a_ok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_nxt.status == sfd_pkg::ST_OK) |=> (state_r.frame_count == '0))
    else $error("parser not idle after good frame");
`endif

endmodule

/* sv/sfd_parse.sv */
// Single-byte parse step: next parser state and the tag for one byte.
`timescale 1ns / 1ps

module sfd_parse #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  sfd_pkg::state_t  state_cur,
  input  logic [7:0]       data_byte,
  output sfd_pkg::state_t  state_nxt,
  output sfd_pkg::result_t result
);

  logic [7:0]         fc;
  logic [7:0]         fc_inc;
  logic               reject;
  sfd_pkg::type_dec_t dec;
  sfd_pkg::state_t    s;
  sfd_pkg::result_t   r;

  always_comb begin
    // length cap restarts the parser before the byte is looked at
    fc     = (state_cur.frame_count >= 8'(MAX_FRAME_BYTES)) ? sfd_pkg::FC_IDLE
                                                            : state_cur.frame_count;
    fc_inc = fc + 8'd1;
    dec    = sfd_pkg::decode_type(data_byte);
    s      = state_cur;
    s.frame_count = fc;
    r      = '0;
    reject = 1'b0;

    priority if (fc == sfd_pkg::FC_IDLE) begin
      if (data_byte != sfd_pkg::SYNC_BYTE) reject = 1'b1;
      else s.frame_count = fc_inc;
    end else if (fc == sfd_pkg::FC_MARK) begin
      if (data_byte != sfd_pkg::MARK_BYTE) begin
        reject = 1'b1;
      end else begin
        s.crc_expected = '0;
        s.crc_running  = '0;
        s.frame_count  = fc_inc;
      end
    end else if (fc < sfd_pkg::FC_COUNT) begin
      s.crc_expected = {state_cur.crc_expected[23:0], data_byte};
      s.frame_count  = fc_inc;
    end else begin
      priority if (fc == sfd_pkg::FC_COUNT) begin
        if (data_byte[7:4] != sfd_pkg::COUNT_NIB) begin
          reject = 1'b1;
        end else begin
          s.objects_left  = data_byte[3:0];
          s.payload_left  = '0;
          s.current_index = '1;
          s.current_kind  = sfd_pkg::KIND_BOOL;
          s.value_shift   = '0;
          r.role          = sfd_pkg::ROLE_COUNT;
        end
      end else if (state_cur.payload_left != '0) begin
        s.payload_left = state_cur.payload_left - 4'd1;
        s.value_shift  = {state_cur.value_shift[55:0], data_byte};
        r.role         = sfd_pkg::ROLE_DATA;
        r.index        = state_cur.current_index;
        r.kind         = state_cur.current_kind;
        r.obj_end      = (s.payload_left == '0);
        r.value        = s.value_shift;
      end else if (state_cur.objects_left != '0) begin
        if (!dec.ok) begin
          reject = 1'b1;
        end else begin
          s.objects_left  = state_cur.objects_left - 4'd1;
          s.payload_left  = dec.len;
          s.current_index = state_cur.current_index + 4'd1;
          s.current_kind  = dec.kind;
          s.value_shift   = (dec.kind == sfd_pkg::KIND_BOOL) ? {63'd0, data_byte[0]} : '0;
          r.role          = sfd_pkg::ROLE_TYPE;
          r.index         = s.current_index;
          r.kind          = dec.kind;
          r.obj_end       = (dec.len == '0);
          r.value         = s.value_shift;
        end
      end else begin
        // nothing outstanding (e.g. right after a CRC mismatch)
        reject = 1'b1;
      end

      if (!reject) begin
        s.crc_running = sfd_pkg::crc_byte(state_cur.crc_running, data_byte);
        s.frame_count = fc_inc;
        if (fc_inc >= sfd_pkg::MIN_FRAME_BYTES && s.objects_left == '0 &&
            s.payload_left == '0) begin
          if (s.crc_running == s.crc_expected) begin
            r.status      = sfd_pkg::ST_OK;
            s.frame_count = sfd_pkg::FC_IDLE;
          end else begin
            r.status = sfd_pkg::ST_CRC_BAD;
          end
        end
      end
    end

    if (reject) begin
      s.frame_count = sfd_pkg::FC_IDLE;
      r             = '0;
      r.status      = sfd_pkg::ST_REJECT;
    end

    state_nxt = s;
    result    = r;
  end

endmodule
